// ===== rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion core.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int DATA_W    = 16;

    // signed width that holds a three-term sum of entries plus one
    localparam int SUM_W     = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
    // unsigned root argument after clamping
    localparam int ARG_W     = SUM_W - 1;
    // radicand of the square root, argument scaled by one
    localparam int RAD_W     = ARG_W + FRAC_BITS;
    localparam int SQ_STEPS  = (RAD_W + 1) / 2;
    localparam int ROOT_W    = SQ_STEPS;
    // magnitude of a numerator, a sum or difference of two entries
    localparam int MAG_W     = DATA_W + 1;
    // divisor is twice the root
    localparam int DIVR_W    = ROOT_W + 1;
    localparam int DVD_W     = MAG_W + FRAC_BITS;
    // quotient bits kept, enough to detect saturation
    localparam int QB        = DATA_W + 1;

    localparam int LANES     = 3;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // slot that gets the root component
    typedef enum logic [1:0] {
        SEL_X = 2'd0,
        SEL_Y = 2'd1,
        SEL_Z = 2'd2,
        SEL_W = 2'd3
    } sel_t;

    typedef struct packed {
        sel_t                           sel;
        logic [ARG_W-1:0]               arg;
        logic [LANES-1:0]               neg;
        logic [LANES-1:0][MAG_W-1:0]    mag;
    } job_t;

endpackage

// ===== rtl/rotation_matrix_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Shepperd rotation matrix to quaternion conversion in Q2.14.
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle when the result is not stalled, set by
// the 16-stage root pipeline and the 18-stage divider pipelines that each take
// a new job every cycle unless m_ready holds the back end
// reset: synchronous active-low aresetn clears all valid state and the queue
module rotation_matrix_to_quaternion_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rmq_pkg::data_t s_m00,
    input  rmq_pkg::data_t s_m01,
    input  rmq_pkg::data_t s_m02,
    input  rmq_pkg::data_t s_m10,
    input  rmq_pkg::data_t s_m11,
    input  rmq_pkg::data_t s_m12,
    input  rmq_pkg::data_t s_m20,
    input  rmq_pkg::data_t s_m21,
    input  rmq_pkg::data_t s_m22,
    output logic           m_valid,
    input  logic           m_ready,
    output rmq_pkg::data_t m_qx,
    output rmq_pkg::data_t m_qy,
    output rmq_pkg::data_t m_qz,
    output rmq_pkg::data_t m_qw
);
    import rmq_pkg::*;

    logic f_valid, f_ready, b_valid, b_ready;
    job_t f_job, b_job;

    rmq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_m00     (s_m00),
        .s_m01     (s_m01),
        .s_m02     (s_m02),
        .s_m10     (s_m10),
        .s_m11     (s_m11),
        .s_m12     (s_m12),
        .s_m20     (s_m20),
        .s_m21     (s_m21),
        .s_m22     (s_m22),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    rmq_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_job   (f_job),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_job   (b_job)
    );

    rmq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job       (b_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_qx      (m_qx),
        .m_qy      (m_qy),
        .m_qz      (m_qz),
        .m_qw      (m_qw)
    );

endmodule

// ===== rtl/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front
// Accepts a matrix, picks the branch, forms the clamped root argument and
// the three numerators, and holds the job in a register for the queue.
// ----------------------------------------------------------------------------
module rmq_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rmq_pkg::data_t    s_m00,
    input  rmq_pkg::data_t    s_m01,
    input  rmq_pkg::data_t    s_m02,
    input  rmq_pkg::data_t    s_m10,
    input  rmq_pkg::data_t    s_m11,
    input  rmq_pkg::data_t    s_m12,
    input  rmq_pkg::data_t    s_m20,
    input  rmq_pkg::data_t    s_m21,
    input  rmq_pkg::data_t    s_m22,
    output logic              job_valid,
    input  logic              job_ready,
    output rmq_pkg::job_t     job
);
    import rmq_pkg::*;

    logic  valid_reg;
    job_t  job_reg;
    job_t  job_next;

    sum_t d0, d1, d2, trace, targ, a;
    sum_t one;
    sum_t n [LANES];
    sel_t sel;

    always_comb begin
        one   = sum_t'(1) <<< FRAC_BITS;
        d0    = sum_t'(s_m00);
        d1    = sum_t'(s_m11);
        d2    = sum_t'(s_m22);
        trace = d0 + d1 + d2;
        targ  = trace + one;
        if (targ > 0) begin
            sel = SEL_W;
        end else if (((s_m00 < s_m11) ? s_m11 : s_m00) < s_m22) begin
            sel = SEL_Z;
        end else if (s_m00 < s_m11) begin
            sel = SEL_Y;
        end else begin
            sel = SEL_X;
        end
        unique case (sel)
            SEL_X: begin
                a    = d0 - (d1 + d2) + one;
                n[0] = sum_t'(s_m01) + sum_t'(s_m10);
                n[1] = sum_t'(s_m02) + sum_t'(s_m20);
                n[2] = sum_t'(s_m12) - sum_t'(s_m21);
            end
            SEL_Y: begin
                a    = d1 - (d2 + d0) + one;
                n[0] = sum_t'(s_m10) + sum_t'(s_m01);
                n[1] = sum_t'(s_m12) + sum_t'(s_m21);
                n[2] = sum_t'(s_m20) - sum_t'(s_m02);
            end
            SEL_Z: begin
                a    = d2 - (d0 + d1) + one;
                n[0] = sum_t'(s_m20) + sum_t'(s_m02);
                n[1] = sum_t'(s_m21) + sum_t'(s_m12);
                n[2] = sum_t'(s_m01) - sum_t'(s_m10);
            end
            default: begin
                a    = targ;
                n[0] = sum_t'(s_m12) - sum_t'(s_m21);
                n[1] = sum_t'(s_m20) - sum_t'(s_m02);
                n[2] = sum_t'(s_m01) - sum_t'(s_m10);
            end
        endcase
        job_next.sel = sel;
        job_next.arg = (a > 0) ? a[ARG_W-1:0] : '0;
        for (int l = 0; l < LANES; l++) begin
            job_next.neg[l] = n[l][SUM_W-1];
            job_next.mag[l] = n[l][SUM_W-1] ? MAG_W'(-n[l]) : MAG_W'(n[l]);
        end
    end

    assign s_ready   = !valid_reg || job_ready;
    assign job_valid = valid_reg;
    assign job       = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            job_reg <= job_next;
        end
    end

endmodule

// ===== rtl/rmq_queue.sv =====
// ----------------------------------------------------------------------------
// rmq_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module rmq_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  rmq_pkg::job_t  wr_job,
    output logic           rd_valid,
    input  logic           rd_ready,
    output rmq_pkg::job_t  rd_job
);
    import rmq_pkg::*;

    job_t        mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_job   = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ===== rtl/rmq_back.sv =====
// ----------------------------------------------------------------------------
// rmq_back
// Pipelined square root, one result bit per stage, then three pipelined
// restoring dividers and a saturating output register.
// ----------------------------------------------------------------------------
module rmq_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           job_valid,
    output logic           job_ready,
    input  rmq_pkg::job_t  job,
    output logic           m_valid,
    input  logic           m_ready,
    output rmq_pkg::data_t m_qx,
    output rmq_pkg::data_t m_qy,
    output rmq_pkg::data_t m_qz,
    output rmq_pkg::data_t m_qw
);
    import rmq_pkg::*;

    localparam int DEPTH = SQ_STEPS + 1 + QB;

    typedef struct packed {
        sel_t                         sel;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0][MAG_W-1:0]  mag;
        logic [RAD_W-1:0]             x;
        logic [RAD_W-1:0]             r;
    } sq_t;

    typedef struct packed {
        sel_t                         sel;
        logic [ROOT_W-1:0]            root;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0]             ovf;
        logic [LANES-1:0][DIVR_W-1:0] rem;
        logic [LANES-1:0][QB-1:0]     low;
        logic [LANES-1:0][QB-1:0]     q;
    } dv_t;

    logic              en;
    logic [DEPTH-1:0]  vld_reg;
    logic              out_valid_reg;
    sq_t               sq_reg  [SQ_STEPS];
    sq_t               sq_next [SQ_STEPS];
    dv_t               dv_reg  [QB+1];
    dv_t               dv_next [QB+1];
    data_t             q_reg  [4];
    data_t             q_next [4];

    assign en        = !out_valid_reg || m_ready;
    assign job_ready = en;
    assign m_valid   = out_valid_reg;
    assign m_qx      = q_reg[0];
    assign m_qy      = q_reg[1];
    assign m_qz      = q_reg[2];
    assign m_qw      = q_reg[3];

    // square root stages
    always_comb begin
        sq_t              s;
        logic [RAD_W-1:0] b;
        logic [RAD_W:0]   t;
        for (int k = 0; k < SQ_STEPS; k++) begin
            if (k == 0) begin
                s.sel = job.sel;
                s.neg = job.neg;
                s.mag = job.mag;
                s.x   = {job.arg, {FRAC_BITS{1'b0}}};
                s.r   = '0;
            end else begin
                s = sq_reg[k-1];
            end
            b = RAD_W'(1) << (2 * (SQ_STEPS - 1 - k));
            t = {1'b0, s.r} + {1'b0, b};
            if ({1'b0, s.x} >= t) begin
                s.x = s.x - t[RAD_W-1:0];
                s.r = (s.r >> 1) + b;
            end else begin
                s.r = s.r >> 1;
            end
            sq_next[k] = s;
        end
    end

    // divider entry and bit stages
    always_comb begin
        dv_t               v;
        logic [DIVR_W-1:0] d;
        logic [DVD_W-1:0]  dvd;
        logic [DVD_W-1:0]  hi;
        logic [DIVR_W:0]   rem2;
        v.sel  = sq_reg[SQ_STEPS-1].sel;
        v.root = sq_reg[SQ_STEPS-1].r[ROOT_W-1:0];
        v.neg  = sq_reg[SQ_STEPS-1].neg;
        d      = {v.root, 1'b0};
        for (int l = 0; l < LANES; l++) begin
            dvd      = {sq_reg[SQ_STEPS-1].mag[l], {FRAC_BITS{1'b0}}};
            hi       = dvd >> QB;
            v.ovf[l] = (hi >= DVD_W'(d));
            v.rem[l] = hi[DIVR_W-1:0];
            v.low[l] = dvd[QB-1:0];
            v.q[l]   = '0;
        end
        dv_next[0] = v;
        for (int k = 1; k <= QB; k++) begin
            v = dv_reg[k-1];
            d = {v.root, 1'b0};
            for (int l = 0; l < LANES; l++) begin
                rem2 = {v.rem[l], v.low[l][QB-1]};
                v.low[l] = v.low[l] << 1;
                if (rem2 >= {1'b0, d}) begin
                    v.rem[l] = DIVR_W'(rem2 - {1'b0, d});
                    v.q[l]   = {v.q[l][QB-2:0], 1'b1};
                end else begin
                    v.rem[l] = rem2[DIVR_W-1:0];
                    v.q[l]   = {v.q[l][QB-2:0], 1'b0};
                end
            end
            dv_next[k] = v;
        end
    end

    // saturation and slot mapping
    always_comb begin
        dv_t        v;
        logic [1:0] lane;
        logic       big;
        data_t      val [LANES];
        v = dv_reg[QB];
        for (int l = 0; l < LANES; l++) begin
            big = v.ovf[l] || v.q[l][QB-1] || v.q[l][QB-2];
            if (v.root == '0) begin
                val[l] = '0;
            end else if (v.neg[l]) begin
                val[l] = big ? data_t'(-32768) : data_t'(-v.q[l]);
            end else begin
                val[l] = big ? data_t'(32767) : data_t'(v.q[l]);
            end
        end
        for (int s = 0; s < 4; s++) begin
            lane = 2'(s) - ((2'(s) > v.sel) ? 2'd1 : 2'd0);
            if (2'(s) == v.sel) begin
                q_next[s] = data_t'(v.root >> 1);
            end else begin
                q_next[s] = val[lane];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg       <= {vld_reg[DEPTH-2:0], job_valid};
            out_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                sq_reg[k] <= sq_next[k];
            end
            for (int k = 0; k <= QB; k++) begin
                dv_reg[k] <= dv_next[k];
            end
            for (int s = 0; s < 4; s++) begin
                q_reg[s] <= q_next[s];
            end
        end
    end

endmodule

// ===== rtl/rmq_checker.sv =====
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the rotation matrix to quaternion core.
// ----------------------------------------------------------------------------
module rmq_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input rmq_pkg::data_t m_qx,
    input rmq_pkg::data_t m_qy,
    input rmq_pkg::data_t m_qz,
    input rmq_pkg::data_t m_qw
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_qx) && $stable(m_qy)
                                && $stable(m_qz) && $stable(m_qw))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input side open right after reset
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // an idle output register never leaves the input blocked without a result turning valid
    a_no_deadlock: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !s_ready |=> s_ready || m_valid)
        else $error("input blocked with empty output");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_qx    (m_qx),
    .m_qy    (m_qy),
    .m_qz    (m_qz),
    .m_qw    (m_qw)
);

// ===== tb/tb_rotation_matrix_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion_core
// Drives rotation matrices into the core and checks each quaternion against
// an in-bench fixed-point Shepperd predictor, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion_core;
    import rmq_pkg::*;

    localparam int ONE = 1 << FRAC_BITS;
    localparam int LATENCY = 36;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        data_t qx;
        data_t qy;
        data_t qz;
        data_t qw;
    } quat_t;

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    data_t s_m00, s_m01, s_m02, s_m10, s_m11, s_m12, s_m20, s_m21, s_m22;
    logic  m_valid;
    logic  m_ready;
    data_t m_qx, m_qy, m_qz, m_qw;

    quat_t  quat_queue[$];
    int     error_count;
    longint cycle_count;
    bit     quiet;
    int     ready_idle;

    rotation_matrix_to_quaternion_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_m00(s_m00), .s_m01(s_m01), .s_m02(s_m02),
        .s_m10(s_m10), .s_m11(s_m11), .s_m12(s_m12),
        .s_m20(s_m20), .s_m21(s_m21), .s_m22(s_m22),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_qx(m_qx), .m_qy(m_qy), .m_qz(m_qz), .m_qw(m_qw)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned root_of(longint a);
        if (a <= 0) return 0;
        return int_sqrt(longint'(a) << FRAC_BITS);
    endfunction

    function automatic longint half_quotient(longint n, longint unsigned root);
        longint unsigned mag;
        longint unsigned q;
        mag = (n < 0) ? longint'(-n) : n;
        q = (mag << FRAC_BITS) / (root * 2);
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic data_t clip16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return data_t'(v);
    endfunction

    function automatic quat_t shepperd_quat(data_t e[9]);
        longint m[3][3];
        longint q[4];
        longint tr;
        longint unsigned root;
        int i, j, k;
        quat_t res;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                m[r][c] = e[r*3+c];
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr + ONE > 0) begin
            root = root_of(tr + ONE);
            q[3] = root >> 1;
            if (root != 0) begin
                q[0] = half_quotient(m[1][2] - m[2][1], root);
                q[1] = half_quotient(m[2][0] - m[0][2], root);
                q[2] = half_quotient(m[0][1] - m[1][0], root);
            end else begin
                q[0] = 0; q[1] = 0; q[2] = 0;
            end
        end else begin
            i = (m[0][0] < m[1][1]) ? 1 : 0;
            if (m[i][i] < m[2][2]) i = 2;
            j = (i == 2) ? 0 : i + 1;
            k = (j == 2) ? 0 : j + 1;
            root = root_of(m[i][i] - (m[j][j] + m[k][k]) + ONE);
            q[i] = root >> 1;
            if (root != 0) begin
                q[3] = half_quotient(m[j][k] - m[k][j], root);
                q[j] = half_quotient(m[i][j] + m[j][i], root);
                q[k] = half_quotient(m[i][k] + m[k][i], root);
            end else begin
                q[3] = 0; q[j] = 0; q[k] = 0;
            end
        end
        res.qx = clip16(q[0]);
        res.qy = clip16(q[1]);
        res.qz = clip16(q[2]);
        res.qw = clip16(q[3]);
        return res;
    endfunction

    task automatic send_matrix(data_t e[9]);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_m00 <= e[0]; s_m01 <= e[1]; s_m02 <= e[2];
        s_m10 <= e[3]; s_m11 <= e[4]; s_m12 <= e[5];
        s_m20 <= e[6]; s_m21 <= e[7]; s_m22 <= e[8];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        quat_queue.push_back(shepperd_quat(e));
    endtask

    task automatic send_diag(int a, int b, int c);
        data_t e[9];
        foreach (e[n]) e[n] = data_t'($urandom);
        e[0] = data_t'(a); e[4] = data_t'(b); e[8] = data_t'(c);
        send_matrix(e);
    endtask

    // random proper rotation built from a random normalized quaternion
    task automatic send_rotation();
        real a, b, c, d, n;
        real r[9];
        data_t e[9];
        a = $urandom_range(0, 2000) - 1000.0;
        b = $urandom_range(0, 2000) - 1000.0;
        c = $urandom_range(0, 2000) - 1000.0;
        d = $urandom_range(0, 2000) - 1000.0;
        n = $sqrt(a*a + b*b + c*c + d*d) + 1e-9;
        a /= n; b /= n; c /= n; d /= n;
        r[0] = 1 - 2*(c*c + d*d); r[1] = 2*(b*c - a*d); r[2] = 2*(b*d + a*c);
        r[3] = 2*(b*c + a*d); r[4] = 1 - 2*(b*b + d*d); r[5] = 2*(c*d - a*b);
        r[6] = 2*(b*d - a*c); r[7] = 2*(c*d + a*b); r[8] = 1 - 2*(b*b + c*c);
        foreach (e[n2]) e[n2] = data_t'($rtoi(r[n2] * ONE) + $urandom_range(0, 8) - 4);
        send_matrix(e);
    endtask

    task automatic test_directed();
        data_t e[9];
        foreach (e[n]) e[n] = '0;
        e[0] = data_t'(ONE); e[4] = data_t'(ONE); e[8] = data_t'(ONE);
        send_matrix(e);                                  // identity
        foreach (e[n]) e[n] = 16'sh7fff;
        send_matrix(e);
        foreach (e[n]) e[n] = -16'sh8000;
        send_matrix(e);                                  // trace plus one negative, x branch
        foreach (e[n]) e[n] = '0;
        e[0] = data_t'(-ONE/3); e[4] = data_t'(-ONE/3); e[8] = data_t'(-ONE/3);
        send_matrix(e);                                  // trace one LSB above minus one, w branch
        send_diag(-ONE, -ONE, ONE);                      // z branch
        send_diag(-ONE, ONE, -ONE);                      // y branch
        send_diag(ONE, -ONE, -ONE);                      // x branch
        send_diag(-ONE, -ONE, -ONE);                     // tie m00 and m11
        send_diag(-ONE/2, -ONE/2, -ONE/2);               // three-way tie
        send_diag(-100, -100, -ONE);
        send_diag(-ONE, -100, -100);
        send_diag(-32768, -32768, -32768);               // three-way tie at the most negative entries
        send_diag(32767, -32768, -32768);
        send_diag(-32768, -32768, 32767);
        foreach (e[n]) e[n] = '0;
        e[1] = 16'sh7fff; e[3] = -16'sh8000;
        e[0] = data_t'(-ONE+1); send_matrix(e);          // tiny root, saturation
        foreach (e[n]) e[n] = (n % 2) ? 16'sh5555 : -16'sh2aab;
        send_matrix(e);
    endtask

    task automatic test_rotations(int count);
        for (int n = 0; n < count; n++) send_rotation();
    endtask

    task automatic test_negative_trace(int count);
        for (int n = 0; n < count; n++)
            send_diag($urandom_range(0, 20000) - 16384, $urandom_range(0, 20000) - 16384,
                      $urandom_range(0, 20000) - 16384 - ONE);
    endtask

    task automatic test_raw(int count);
        data_t e[9];
        for (int n = 0; n < count; n++) begin
            foreach (e[b]) e[b] = data_t'($urandom);
            send_matrix(e);
        end
    endtask

    task automatic test_steady(int count);
        quiet = 1'b1;
        for (int n = 0; n < count; n++)
            if (n % 2) send_rotation(); else test_raw(1);
    endtask

    // result side: ready bursts and checking
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_idle <= 0;
        end else begin
            if (quiet) begin
                m_ready <= 1'b1;
            end else if (ready_idle > 0) begin
                ready_idle <= ready_idle - 1;
                m_ready    <= (ready_idle == 1);
            end else if ($urandom_range(0, 3) == 0) begin
                ready_idle <= $urandom_range(1, 10);
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
            if (m_valid && m_ready) begin
                if (quat_queue.size() == 0) begin
                    $display("%0t: unexpected transaction qx=%0d qy=%0d qz=%0d qw=%0d",
                             $time, m_qx, m_qy, m_qz, m_qw);
                    error_count++;
                end else begin
                    quat_t want;
                    want = quat_queue.pop_front();
                    if (m_qx !== want.qx) begin
                        $display("%0t: qx expected %0d actual %0d", $time, want.qx, m_qx);
                        error_count++;
                    end
                    if (m_qy !== want.qy) begin
                        $display("%0t: qy expected %0d actual %0d", $time, want.qy, m_qy);
                        error_count++;
                    end
                    if (m_qz !== want.qz) begin
                        $display("%0t: qz expected %0d actual %0d", $time, want.qz, m_qz);
                        error_count++;
                    end
                    if (m_qw !== want.qw) begin
                        $display("%0t: qw expected %0d actual %0d", $time, want.qw, m_qw);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        quiet = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        {s_m00, s_m01, s_m02, s_m10, s_m11, s_m12, s_m20, s_m21, s_m22} = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_rotations(700);
        test_negative_trace(400);
        test_raw(350);
        test_steady(280);
        s_valid <= 1'b0;
        while (quat_queue.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
